// File: hdl/pinned_id_set_table_assert.svh
// Assertion macros for the pinned id table checker.
`ifndef PINNED_ID_SET_TABLE_ASSERT_SVH
`define PINNED_ID_SET_TABLE_ASSERT_SVH

// Check a property on the rising clock edge, ignored while reset is held.
`define PIST_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("pinned id table: assertion failed");

// Check a property on every rising clock edge, reset included.
`define PIST_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("pinned id table: assertion failed");

`endif

// File: hdl/pist_pkg.sv
// Package with shared types and constants of the pinned id table.
package pist_pkg;

  localparam int unsigned DefPinCapacity = 64;
  localparam int unsigned IdW            = 15;
  localparam int unsigned LevelW         = 8;
  localparam int unsigned CountOutW      = 7;
  localparam logic [IdW-1:0] MaxReservedId = 15'd2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [CountOutW-1:0] pinned_count;
    status_e              status;
  } result_t;

endpackage

// File: hdl/pinned_id_set_table.sv
// Pinned id table, one request in work at a time. A rejected request goes
// straight to the result; a pin or a miss walks the pinned ids, and an unpin
// also compacts the list behind the removed id. The walk reads the id RAM one
// entry a cycle. The result register lets a new request enter while a
// result waits. Reset clears the count and control; RAM needs no clearing pass.
module pinned_id_set_table #(
  parameter int unsigned PIN_CAPACITY = pist_pkg::DefPinCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // [14:0] process_id, [22:15] level, [23] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // [1:0] status, [8:2] pinned_count, [15:9] zero
);

  logic              res_valid, res_ready;
  pist_pkg::result_t res;
  logic              out_valid_q;
  pist_pkg::result_t out_q;

  pist_ctrl #(
    .PIN_CAPACITY (PIN_CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_id_i     (s_axis_tdata_i[14:0]),
    .in_level_i  (s_axis_tdata_i[22:15]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Take a result when the output register is empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_q};

endmodule

// File: hdl/pist_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pist_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write the addressed entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/pist_ctrl.sv
// Sequencer that searches, appends to and compacts the pinned id list in RAM.
module pist_ctrl #(
  parameter int unsigned PIN_CAPACITY = pist_pkg::DefPinCapacity
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [pist_pkg::IdW-1:0]         in_id_i,
  input  logic signed [pist_pkg::LevelW-1:0] in_level_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output pist_pkg::result_t                res_o
);

  localparam int unsigned AddrW = (PIN_CAPACITY > 1) ? $clog2(PIN_CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(PIN_CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(PIN_CAPACITY);

  pist_pkg::state_e  state_q, state_d;
  pist_pkg::status_e status_q, status_d;
  logic [pist_pkg::IdW-1:0] id_q, id_d;
  logic             pin_q, pin_d;
  logic [CntW-1:0]  k_q, k_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             rv_q, rv_d;
  logic [AddrW-1:0] kp_q, kp_d;
  logic [AddrW-1:0] wa_q, wa_d;

  logic             issue;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [pist_pkg::IdW-1:0] ram_wdata, ram_rdata;
  logic [CntW+pist_pkg::CountOutW-1:0] cnt_ext;

  pist_ram #(
    .Width (pist_pkg::IdW),
    .Depth (PIN_CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pist_pkg::S_IDLE;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
    end
  end

  // Hold the request and walk pointers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    id_q     <= id_d;
    pin_q    <= pin_d;
    k_q      <= k_d;
    kp_q     <= kp_d;
    wa_q     <= wa_d;
  end

  assign issue = (k_q < cnt_q);

  // Next state, RAM accesses and result
  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    id_d        = id_q;
    pin_d       = pin_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    rv_d        = 1'b0;
    kp_d        = kp_q;
    wa_d        = wa_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = k_q[AddrW-1:0];
    ram_we      = 1'b0;
    ram_waddr   = wa_q;
    ram_wdata   = ram_rdata;

    unique case (state_q)
      pist_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          id_d  = in_id_i;
          pin_d = (in_level_i == '0);
          k_d   = '0;
          if ((in_id_i <= pist_pkg::MaxReservedId) || in_level_i[pist_pkg::LevelW-1]) begin
            status_d = pist_pkg::ST_REJECT;
            state_d  = pist_pkg::S_RESP;
          end else begin
            state_d = pist_pkg::S_SEARCH;
          end
        end
      end

      pist_pkg::S_SEARCH: begin
        // Stream reads over the valid entries, compare each in the cycle after its read
        ram_re = issue;
        rv_d   = issue;
        kp_d   = k_q[AddrW-1:0];
        if (issue) begin
          k_d = k_q + 1'b1;
        end
        if (rv_q && (ram_rdata == id_q)) begin
          rv_d = 1'b0;
          if (pin_q) begin
            status_d = pist_pkg::ST_OK;
            state_d  = pist_pkg::S_RESP;
          end else begin
            k_d     = CntW'(kp_q) + 1'b1;
            state_d = pist_pkg::S_SHIFT;
          end
        end else if (!issue && !rv_q) begin
          if (!pin_q) begin
            status_d = pist_pkg::ST_ABSENT;
          end else if (cnt_q >= CapCnt) begin
            status_d = pist_pkg::ST_FULL;
          end else begin
            // Append the id at the end of the list
            ram_we    = 1'b1;
            ram_waddr = cnt_q[AddrW-1:0];
            ram_wdata = id_q;
            cnt_d     = cnt_q + 1'b1;
            status_d  = pist_pkg::ST_OK;
          end
          state_d = pist_pkg::S_RESP;
        end
      end

      pist_pkg::S_SHIFT: begin
        // Read entry k, write it back one place lower in the next cycle
        ram_re = issue;
        rv_d   = issue;
        wa_d   = k_q[AddrW-1:0] - 1'b1;
        if (issue) begin
          k_d = k_q + 1'b1;
        end
        if (rv_q) begin
          ram_we = 1'b1;
        end
        if (!issue && !rv_q) begin
          cnt_d    = cnt_q - 1'b1;
          status_d = pist_pkg::ST_OK;
          state_d  = pist_pkg::S_RESP;
        end
      end

      pist_pkg::S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = pist_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = pist_pkg::S_IDLE;
      end
    endcase
  end

  // Report the count masked to the output width
  assign cnt_ext             = {{pist_pkg::CountOutW{1'b0}}, cnt_q};
  assign res_o.pinned_count  = cnt_ext[pist_pkg::CountOutW-1:0];
  assign res_o.status        = status_q;

endmodule

// File: hdl/pist_checker.sv
// Port-level checker for the pinned id table, bound to the top level.
`include "pinned_id_set_table_assert.svh"

module pist_checker #(
  parameter int unsigned PIN_CAPACITY = pist_pkg::DefPinCapacity
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  localparam bit CapFits = (PIN_CAPACITY < 128);
  localparam logic [6:0] CapOut = 7'(PIN_CAPACITY);

  logic       in_acc;
  logic       out_stall;
  logic       out_live;
  logic       full_seen;
  logic [6:0] out_count;

  // Pick out the handshakes and the result fields
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_live  = m_axis_tvalid_o && CapFits;
  assign out_count = m_axis_tdata_o[8:2];
  assign full_seen = out_live && (m_axis_tdata_o[1:0] == pist_pkg::ST_FULL);

  // Hold a stalled result
  `PIST_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))

  // Never report more ids than the table holds
  `PIST_ASSERT_ALWAYS(a_count_bound, clk_i, out_live |-> (out_count <= CapOut))

  // Report a full table only with every slot taken
  `PIST_ASSERT(a_full_count, clk_i, rst_ni, full_seen |-> (out_count == CapOut))

  // Take no new request in the cycle after one was accepted
  `PIST_ASSERT(a_one_in_work, clk_i, rst_ni, in_acc |=> !s_axis_tready_o)

endmodule

bind pinned_id_set_table pist_checker #(.PIN_CAPACITY(PIN_CAPACITY)) u_pist_checker (.*);
